@@ design/csp_pkg.sv @@
// Package for the CDMA SMS transport PDU parser: parser state, result types,
// parameter codes and the per-field bit extraction steps.
// No dependencies; used by cdma_sms_pdu_parser and csp_chk.
package csp_pkg;

  // Top-level parameter walk
  typedef enum logic [1:0] {
    OP_TYPE,
    OP_CODE,
    OP_LEN,
    OP_BODY
  } op_e;

  // Subparameter walk, also reused for the address digit run
  typedef enum logic [2:0] {
    IP_CODE,
    IP_LEN,
    IP_ENC,
    IP_COUNT,
    IP_CHAR,
    IP_LOW,
    IP_SKIP,
    IP_VM
  } ip_e;

  // Kind of a result request
  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_CHAR,
    KIND_SUMMARY
  } kind_e;

  // Parameter and subparameter codes
  localparam logic [7:0] CODE_ADDR   = 8'd2;
  localparam logic [7:0] CODE_BEARER = 8'd8;
  localparam logic [7:0] SUB_USER    = 8'd1;
  localparam logic [7:0] SUB_VM      = 8'd11;
  localparam logic [7:0] VM_SUB_LEN  = 8'd1;

  // User data encodings that are decoded
  localparam logic [4:0] ENC_OCTET   = 5'd0;
  localparam logic [4:0] ENC_ASCII7  = 5'd2;
  localparam logic [4:0] ENC_IA5     = 5'd3;
  localparam logic [4:0] ENC_UNICODE = 5'd4;
  localparam logic [4:0] ENC_LATIN   = 5'd8;

  // Voicemail summary codes
  localparam logic [1:0] VM_NONE    = 2'd0;
  localparam logic [1:0] VM_EMPTY   = 2'd1;
  localparam logic [1:0] VM_WAITING = 2'd2;

  // Field widths taken from the bit buffer
  localparam logic [4:0] ADDR_HDR_BITS = 5'd10;
  localparam logic [4:0] DIGIT_BITS    = 5'd4;
  localparam logic [4:0] ENC_BITS      = 5'd5;
  localparam logic [4:0] BYTE_BITS     = 5'd8;
  localparam logic [4:0] SEPT_BITS     = 5'd7;
  localparam logic [4:0] BUF_BITS      = 5'd16;

  // Result queue sizing
  localparam int RQ_DEPTH = 4;
  localparam int MAX_RES  = 3;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    op_e         op;
    logic [7:0]  oc;
    logic [7:0]  ol;
    ip_e         ip;
    logic [7:0]  ic;
    logic [7:0]  il;
    logic [15:0] bits;
    logic [4:0]  nbits;
    logic [4:0]  enc;
    logic [7:0]  items;
    logic [1:0]  vm;
    logic        bad;
    logic        addr;
    logic        msg;
  } pst_t;

  localparam pst_t PST_RESET = '{
    op: OP_TYPE, oc: 8'h00, ol: 8'h00, ip: IP_CODE, ic: 8'h00, il: 8'h00,
    bits: 16'h0000, nbits: 5'd0, enc: 5'd0, items: 8'h00, vm: VM_NONE,
    bad: 1'b0, addr: 1'b0, msg: 1'b0
  };

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       bad;
    logic [1:0] vm;
    logic       addr;
    logic       msg;
    logic       last;
  } res_t;

  // Outcome of one extraction step
  typedef struct packed {
    pst_t       s;
    logic       emit;
    kind_e      kind;
    logic [7:0] ch;
  } stp_t;

  // Map a 4-bit address digit to ASCII
  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: c = 8'h30 + {4'h0, d};
      4'd10:   c = 8'h30;
      4'd11:   c = 8'h2A;
      4'd12:   c = 8'h23;
      default: c = 8'h2E;
    endcase
    return c;
  endfunction

  // Append one byte to the bit buffer, count saturating at 16
  function automatic pst_t push_byte(pst_t s, logic [7:0] b);
    pst_t r;
    r = s;
    r.bits  = {s.bits[7:0], b};
    r.nbits = (s.nbits >= BYTE_BITS) ? BUF_BITS : s.nbits + BYTE_BITS;
    return r;
  endfunction

  // Take one field off the bit buffer if enough bits are held
  function automatic stp_t bit_step(pst_t s, logic addr_mode);
    stp_t       r;
    logic [4:0] need;
    logic [15:0] sh;
    r      = '0;
    r.s    = s;
    r.kind = addr_mode ? KIND_DIGIT : KIND_CHAR;
    need   = 5'd0;
    if (addr_mode) begin
      case (s.ip)
        IP_COUNT: need = ADDR_HDR_BITS;
        IP_CHAR:  need = DIGIT_BITS;
        default:  need = 5'd0;
      endcase
    end else begin
      case (s.ip)
        IP_ENC:   need = ENC_BITS;
        IP_COUNT: need = BYTE_BITS;
        IP_CHAR:  need = (s.enc == ENC_ASCII7 || s.enc == ENC_IA5) ? SEPT_BITS : BYTE_BITS;
        IP_LOW:   need = BYTE_BITS;
        default:  need = 5'd0;
      endcase
    end
    sh = s.bits >> (s.nbits - need);
    if (need != 5'd0 && s.nbits >= need) begin
      r.s.nbits = s.nbits - need;
      case (s.ip)
        IP_ENC: begin
          r.s.enc = sh[4:0];
          if (sh[4:0] == ENC_OCTET || sh[4:0] == ENC_ASCII7 || sh[4:0] == ENC_IA5 ||
              sh[4:0] == ENC_UNICODE || sh[4:0] == ENC_LATIN) begin
            r.s.ip = IP_COUNT;
          end else begin
            r.s.bad = 1'b1;
            r.s.ip  = IP_SKIP;
          end
        end
        IP_COUNT: begin
          r.s.items = sh[7:0];
          r.s.ip    = (sh[7:0] != 8'h00) ? IP_CHAR : IP_SKIP;
        end
        IP_CHAR: begin
          if (!addr_mode && s.enc == ENC_UNICODE) begin
            // drop the high byte, keep the low one for the next step
            r.s.ip = IP_LOW;
          end else begin
            r.emit    = 1'b1;
            r.ch      = addr_mode ? digit_char(sh[3:0]) :
                        (need == SEPT_BITS) ? {1'b0, sh[6:0]} : sh[7:0];
            r.s.items = s.items - 8'd1;
            if (s.items == 8'd1) r.s.ip = IP_SKIP;
          end
        end
        IP_LOW: begin
          r.emit    = 1'b1;
          r.ch      = sh[7:0];
          r.s.items = s.items - 8'd1;
          r.s.ip    = (s.items != 8'd1) ? IP_CHAR : IP_SKIP;
        end
        default: r.emit = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Close a subparameter; a run still open there is an overrun
  function automatic pst_t end_inner(pst_t s);
    pst_t r;
    r = s;
    if (s.ip == IP_ENC || s.ip == IP_COUNT || s.ip == IP_CHAR || s.ip == IP_LOW) r.bad = 1'b1;
    r.ip    = IP_CODE;
    r.nbits = 5'd0;
    r.bits  = 16'h0000;
    return r;
  endfunction

  // Close a top-level parameter
  function automatic pst_t end_outer(pst_t s);
    pst_t r;
    r = s;
    if (s.oc == CODE_ADDR) begin
      if (s.ip == IP_COUNT || s.ip == IP_CHAR) r.bad = 1'b1;
      r.ip    = IP_CODE;
      r.nbits = 5'd0;
      r.bits  = 16'h0000;
    end else begin
      r = end_inner(s);
    end
    r.op = OP_CODE;
    return r;
  endfunction

endpackage

@@ design/cdma_sms_pdu_parser.sv @@
// CDMA SMS transport PDU parser, top level: byte walk, result build and
// result queue. Depends on csp_pkg.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata = pdu_byte, tlast = last_byte
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata = flags + char, tuser = kind,
//                                                 tlast = last_result
//
// One PDU byte is taken per cycle while the input is ready and parsed in the
// cycle it is accepted; its zero to three results enter a four-entry queue and
// leave one per cycle while the output is ready.
// A byte is accepted whenever the queue has room for three results, i.e.
// while at most one result is still waiting.
// Reset clears the parse state and empties the queue.
module cdma_sms_pdu_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pdu_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] char_value, [8] bad_encoding,
                                        // [10:9] voicemail, [11] address_seen,
                                        // [12] message_seen, [15:13] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last_result
);

  localparam int AW = csp_pkg::RQ_AW;
  localparam int CW = csp_pkg::RQ_CW;

  csp_pkg::pst_t st_q, st_d;
  csp_pkg::pst_t pushed, bits_done;
  csp_pkg::stp_t stp_a, stp_b;
  csp_pkg::res_t res [csp_pkg::MAX_RES];
  csp_pkg::res_t sum_res;
  csp_pkg::res_t rq_q [csp_pkg::RQ_DEPTH];

  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    n_res;
  logic          run_bits;
  logic          addr_mode;
  logic          accept, pop;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign pop    = m_axis_tvalid_o & m_axis_tready_i;

  // Bit buffer path: push the byte, then up to two field extractions
  assign addr_mode = (st_q.oc == csp_pkg::CODE_ADDR);
  assign pushed    = csp_pkg::push_byte(st_q, s_axis_tdata_i);
  assign stp_a     = csp_pkg::bit_step(pushed, addr_mode);
  assign stp_b     = csp_pkg::bit_step(stp_a.s, addr_mode);

  always_comb begin
    bits_done = stp_b.s;
    if (bits_done.ip == csp_pkg::IP_SKIP) bits_done.nbits = 5'd0;
  end

  // Next parse state for the byte on the input
  always_comb begin
    st_d     = st_q;
    run_bits = 1'b0;
    sum_res  = '0;
    case (st_q.op)
      csp_pkg::OP_TYPE: st_d.op = csp_pkg::OP_CODE;
      csp_pkg::OP_CODE: begin
        st_d.oc = s_axis_tdata_i;
        st_d.op = csp_pkg::OP_LEN;
      end
      csp_pkg::OP_LEN: begin
        st_d.ol    = s_axis_tdata_i;
        st_d.nbits = 5'd0;
        st_d.bits  = 16'h0000;
        if (addr_mode) begin
          st_d.addr = 1'b1;
          st_d.ip   = csp_pkg::IP_COUNT;
        end else begin
          st_d.ip = csp_pkg::IP_CODE;
        end
        st_d.op = csp_pkg::OP_BODY;
        if (s_axis_tdata_i == 8'h00) st_d = csp_pkg::end_outer(st_d);
      end
      default: begin
        if (addr_mode) begin
          if (st_q.ip == csp_pkg::IP_COUNT || st_q.ip == csp_pkg::IP_CHAR) begin
            run_bits = 1'b1;
            st_d     = bits_done;
          end
        end else if (st_q.oc == csp_pkg::CODE_BEARER) begin
          case (st_q.ip)
            csp_pkg::IP_CODE: begin
              st_d.ic = s_axis_tdata_i;
              st_d.ip = csp_pkg::IP_LEN;
            end
            csp_pkg::IP_LEN: begin
              st_d.il    = s_axis_tdata_i;
              st_d.nbits = 5'd0;
              st_d.bits  = 16'h0000;
              if (st_q.ic == csp_pkg::SUB_USER) begin
                st_d.msg = 1'b1;
                st_d.ip  = csp_pkg::IP_ENC;
              end else if (st_q.ic == csp_pkg::SUB_VM &&
                           s_axis_tdata_i == csp_pkg::VM_SUB_LEN) begin
                st_d.ip = csp_pkg::IP_VM;
              end else begin
                st_d.ip = csp_pkg::IP_SKIP;
              end
              if (s_axis_tdata_i == 8'h00) st_d = csp_pkg::end_inner(st_d);
            end
            default: begin
              if (st_q.ip == csp_pkg::IP_VM) begin
                st_d.vm = (s_axis_tdata_i != 8'h00) ? csp_pkg::VM_WAITING : csp_pkg::VM_EMPTY;
              end else if (st_q.ip != csp_pkg::IP_SKIP) begin
                run_bits = 1'b1;
                st_d     = bits_done;
              end
              st_d.il = st_d.il - 8'd1;
              if (st_d.il == 8'h00) st_d = csp_pkg::end_inner(st_d);
            end
          endcase
        end
        st_d.ol = st_d.ol - 8'd1;
        if (st_d.ol == 8'h00) st_d = csp_pkg::end_outer(st_d);
      end
    endcase
    // close the PDU: summary from the final flags, then back to reset state
    if (s_axis_tlast_i) begin
      if (st_d.op == csp_pkg::OP_BODY) st_d = csp_pkg::end_outer(st_d);
      sum_res.kind = csp_pkg::KIND_SUMMARY;
      sum_res.bad  = st_d.bad;
      sum_res.vm   = st_d.vm;
      sum_res.addr = st_d.addr;
      sum_res.msg  = st_d.msg;
      sum_res.last = 1'b1;
      st_d         = csp_pkg::PST_RESET;
    end
  end

  // Pack the results of this byte in order
  always_comb begin
    for (int i = 0; i < csp_pkg::MAX_RES; i++) res[i] = '0;
    n_res = 2'd0;
    if (run_bits && stp_a.emit) begin
      res[n_res].kind = stp_a.kind;
      res[n_res].ch   = stp_a.ch;
      n_res           = n_res + 2'd1;
    end
    if (run_bits && stp_b.emit) begin
      res[n_res].kind = stp_b.kind;
      res[n_res].ch   = stp_b.ch;
      n_res           = n_res + 2'd1;
    end
    if (s_axis_tlast_i) begin
      res[n_res] = sum_res;
      n_res      = n_res + 2'd1;
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = wr_ptr_q + AW'(n_res);
      cnt_d    = cnt_d + CW'(n_res);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
      cnt_d    = cnt_d - CW'(1);
    end
  end

  // Hold parse state and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= csp_pkg::PST_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) st_q <= st_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write this byte's results into the queue
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < csp_pkg::MAX_RES; i++) begin
      if (accept && (2'(i) < n_res)) rq_q[wr_ptr_q + AW'(i)] <= res[i];
    end
  end

  // Accept while the queue can take a full set of results
  assign s_axis_tready_o = (cnt_q <= CW'(csp_pkg::RQ_DEPTH - csp_pkg::MAX_RES));

  // Present the queue head
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {3'b000, rq_q[rd_ptr_q].msg, rq_q[rd_ptr_q].addr,
                            rq_q[rd_ptr_q].vm, rq_q[rd_ptr_q].bad, rq_q[rd_ptr_q].ch};
  assign m_axis_tuser_o  = rq_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = rq_q[rd_ptr_q].last;

endmodule

@@ design/csp_chk.sv @@
// Port checker for the CDMA SMS transport PDU parser, bound to the top level.
// Depends on csp_pkg and cdma_sms_pdu_parser.
module csp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result request changed while stalled");

  // Close a PDU only with its summary
  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == csp_pkg::KIND_SUMMARY)))
    else $error("tlast and summary kind disagree");

  // A final byte leaves at least its summary waiting
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("no result after final PDU byte");

  // Input stalls only behind waiting results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // Digits and characters carry no summary flags
  a_char_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != csp_pkg::KIND_SUMMARY) |->
      (m_axis_tdata_o[15:8] == 8'h00))
    else $error("summary flags set on a character request");

endmodule

bind cdma_sms_pdu_parser csp_chk u_csp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
